>>> sv/msie_pkg.sv
// ----------------------------------------------------------------------------
// msie_pkg
// Opcodes, fault codes and field widths shared by the execute unit.
// ----------------------------------------------------------------------------
package msie_pkg;

	localparam int OP_W   = 4;
	localparam int REG_W  = 5;
	localparam int DATA_W = 32;
	localparam int PC_W   = 10;
	localparam int FLT_W  = 2;

	// program depth; a power of two so the counter and targets wrap naturally
	localparam int PROG_DEPTH = 1024;

	typedef enum logic [OP_W-1:0] {
		OP_ADD  = 4'd0,
		OP_SUB  = 4'd1,
		OP_MUL  = 4'd2,
		OP_DIV  = 4'd3,
		OP_SLT  = 4'd4,
		OP_ADDI = 4'd5,
		OP_SUBI = 4'd6,
		OP_SLTI = 4'd7,
		OP_BEQ  = 4'd8,
		OP_BNE  = 4'd9,
		OP_J    = 4'd10,
		OP_LW   = 4'd11,
		OP_SW   = 4'd12,
		OP_HALT = 4'd13
	} op_t;

	typedef enum logic [FLT_W-1:0] {
		FLT_NONE  = 2'd0,
		FLT_DIV0  = 2'd1,
		FLT_RANGE = 2'd2
	} fault_t;

endpackage

>>> sv/msie_div.sv
// ----------------------------------------------------------------------------
// msie_div
// Signed 32-bit divider, one quotient bit per cycle, truncating toward zero.
// ----------------------------------------------------------------------------
module msie_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [31:0] dividend,
	input  logic [31:0] divisor,
	output logic        done,
	output logic [31:0] quotient
);
	import msie_pkg::*;

	logic        busy_q;
	logic [5:0]  cnt_q;
	logic [31:0] rem_q;
	logic [31:0] quo_q;
	logic [31:0] dvs_q;
	logic        neg_q;
	logic [32:0] trial;
	logic [31:0] shifted;

	// restoring step
	assign shifted = {rem_q[30:0], quo_q[31]};
	assign trial   = {1'b0, shifted} - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done   <= 1'b0;
		end else begin
			// pulse after the last step
			done <= !start && busy_q && (cnt_q == 6'd1);
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 6'd32;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1)
					busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend[31] ? (32'd0 - dividend) : dividend;
			dvs_q <= divisor[31] ? (32'd0 - divisor) : divisor;
			neg_q <= dividend[31] ^ divisor[31];
		end else if (busy_q) begin
			if (!trial[32]) begin
				rem_q <= trial[31:0];
				quo_q <= {quo_q[30:0], 1'b1};
			end else begin
				rem_q <= shifted;
				quo_q <= {quo_q[30:0], 1'b0};
			end
		end
	end

	assign quotient = neg_q ? (32'd0 - quo_q) : quo_q;

endmodule

>>> sv/mips_subset_instruction_execute_unit.sv
// ----------------------------------------------------------------------------
// mips_subset_instruction_execute_unit
// Executes one decoded instruction per transfer against a register file
// and a word-addressed data memory, and reports the architectural effects.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_stall) carries one decoded instruction per
//   transfer; output channel (out_valid/out_stall) returns one result.
//   One instruction is in flight at a time: in_stall is high from the
//   transfer until its result has been taken.
//   Path from input transfer to out_valid for most ops: register file
//   read, data memory read, execute into result register; div adds the
//   bit-serial divider. mul uses one extra register stage after the
//   multiplier.
//   After reset a clearing pass walks the data memory, one word a
//   cycle, with in_stall held high.
//   While out_stall is high the result register holds its value and no
//   new instruction is taken.
//   After a halt, items are taken and answered without changing state.
// ----------------------------------------------------------------------------
module mips_subset_instruction_execute_unit #(
	parameter int REG_COUNT  = 32,
	parameter int DATA_WORDS = 1024
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [msie_pkg::OP_W-1:0]   op,
	input  logic [msie_pkg::REG_W-1:0]  dst,
	input  logic [msie_pkg::REG_W-1:0]  src_a,
	input  logic [msie_pkg::REG_W-1:0]  src_b,
	input  logic signed [31:0]          immediate,
	input  logic [msie_pkg::PC_W-1:0]   target,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [msie_pkg::PC_W-1:0]   next_pc,
	output logic                        halted,
	output logic                        reg_written,
	output logic [msie_pkg::REG_W-1:0]  written_reg,
	output logic signed [31:0]          written_value,
	output logic                        mem_written,
	output logic [msie_pkg::PC_W-1:0]   mem_index,
	output logic [msie_pkg::FLT_W-1:0]  fault_code,
	output logic [31:0]                 executed_count
);
	import msie_pkg::*;

	localparam int RA_W = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;
	localparam int MA_W = (DATA_WORDS > 1) ? $clog2(DATA_WORDS) : 1;
	localparam int PCI_W = $clog2(PROG_DEPTH);

	typedef enum logic [2:0] {
		ST_CLEAR, ST_IDLE, ST_RREG, ST_MEM, ST_MUL, ST_DIV, ST_EXEC, ST_OUT
	} state_t;

	state_t state_q;

	// register file and data memory
	logic [31:0] rf_mem [REG_COUNT];
	logic [31:0] dm_mem [DATA_WORDS];
	logic [31:0] rf_a_q, rf_b_q, dm_rd_q;
	logic [RA_W-1:0] rf_ra, rf_rb, rf_wa;
	logic [31:0] rf_wd;
	logic        rf_we;
	logic [MA_W-1:0] dm_addr;
	logic [31:0] dm_wd;
	logic        dm_we;
	logic [MA_W:0] clr_q;
	logic [REG_COUNT-1:0] rf_vld_q;

	// latched instruction
	op_t         op_q;
	logic [4:0]  dst_q, sa_q, sb_q;
	logic [31:0] imm_q;
	logic [9:0]  tgt_q;

	logic [PCI_W-1:0] pc_q;
	logic [31:0]      cnt_q;
	logic             halt_q;

	logic [31:0] a_v, b_v, addr_sum, mag, mul_q;
	logic        idx_ok;
	logic [31:0] idx_w;
	logic        div_start, div_done;
	logic [31:0] div_quo;

	// operand selection, out-of-range, zero and never-written registers read as zero
	assign a_v = (sa_q != 5'd0 && {2'b00, sa_q} < 7'(REG_COUNT) && rf_vld_q[rf_ra])
		? rf_a_q : 32'd0;
	assign b_v = (sb_q != 5'd0 && {2'b00, sb_q} < 7'(REG_COUNT) && rf_vld_q[rf_rb])
		? rf_b_q : 32'd0;
	assign rf_ra = RA_W'(sa_q);
	assign rf_rb = RA_W'(sb_q);

	// word index check
	assign addr_sum = a_v + imm_q;
	assign mag      = addr_sum[31] ? (32'd0 - addr_sum) : addr_sum;
	always_comb begin
		idx_ok = 1'b0;
		idx_w  = 32'd0;
		if (addr_sum[31]) begin
			idx_ok = (mag[31:2] == 30'd0);
		end else begin
			idx_w  = {2'b00, addr_sum[31:2]};
			idx_ok = ({1'b0, idx_w} < 33'(DATA_WORDS));
		end
	end

	msie_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (a_v),
		.divisor  (b_v),
		.done     (div_done),
		.quotient (div_quo)
	);
	assign div_start = (state_q == ST_MEM) && (op_q == OP_DIV) && (b_v != 32'd0);

	// register file: read registered, write port
	always_ff @(posedge clk) begin
		rf_a_q <= rf_mem[rf_ra];
		rf_b_q <= rf_mem[rf_rb];
		if (rf_we)
			rf_mem[rf_wa] <= rf_wd;
	end

	// data memory: single port, read registered
	always_ff @(posedge clk) begin
		if (dm_we)
			dm_mem[dm_addr] <= dm_wd;
		dm_rd_q <= dm_mem[dm_addr];
	end

	always_ff @(posedge clk)
		mul_q <= a_v * b_v;

	assign dm_addr = (state_q == ST_CLEAR) ? clr_q[MA_W-1:0] : idx_w[MA_W-1:0];
	assign dm_we   = (state_q == ST_CLEAR) ||
		((state_q == ST_MEM) && !halt_q && (op_q == OP_SW) && idx_ok);
	assign dm_wd   = (state_q == ST_CLEAR) ? 32'd0 : b_v;

	// execute result
	logic        ex_reg;
	logic [31:0] ex_val;
	logic [PCI_W-1:0] ex_pc;
	logic        ex_memw;
	logic [9:0]  ex_midx;
	fault_t      ex_flt;
	logic        ex_lt;
	logic        dst_ok;

	assign dst_ok = (dst_q != 5'd0) && ({2'b00, dst_q} < 7'(REG_COUNT));
	assign rf_wa  = RA_W'(dst_q);
	assign ex_lt  = ($signed(a_v) < $signed((op_q == OP_SLTI) ? imm_q : b_v));

	always_comb begin
		ex_reg  = 1'b0;
		ex_val  = 32'd0;
		ex_pc   = PCI_W'(pc_q + 1'b1);
		ex_memw = 1'b0;
		ex_midx = 10'd0;
		ex_flt  = FLT_NONE;
		case (op_q)
			OP_ADD:  begin ex_reg = 1'b1; ex_val = a_v + b_v; end
			OP_SUB:  begin ex_reg = 1'b1; ex_val = a_v - b_v; end
			OP_MUL:  begin ex_reg = 1'b1; ex_val = mul_q; end
			OP_DIV: begin
				ex_reg = 1'b1;
				if (b_v == 32'd0) ex_flt = FLT_DIV0;
				else ex_val = div_quo;
			end
			OP_SLT, OP_SLTI: begin ex_reg = 1'b1; ex_val = {31'd0, ex_lt}; end
			OP_ADDI: begin ex_reg = 1'b1; ex_val = a_v + imm_q; end
			OP_SUBI: begin ex_reg = 1'b1; ex_val = a_v - imm_q; end
			OP_BEQ:  if (a_v == b_v) ex_pc = PCI_W'(tgt_q);
			OP_BNE:  if (a_v != b_v) ex_pc = PCI_W'(tgt_q);
			OP_J:    ex_pc = PCI_W'(tgt_q);
			OP_LW: begin
				ex_reg = 1'b1;
				if (idx_ok) begin
					ex_val  = dm_rd_q;
					ex_midx = idx_w[9:0];
				end else ex_flt = FLT_RANGE;
			end
			OP_SW: begin
				if (idx_ok) begin
					ex_memw = 1'b1;
					ex_val  = b_v;
					ex_midx = idx_w[9:0];
				end else ex_flt = FLT_RANGE;
			end
			OP_HALT: ex_pc = pc_q;
			default: ;
		endcase
		if (ex_reg && !dst_ok) begin
			ex_reg = 1'b0;
			ex_val = 32'd0;
		end
	end

	assign rf_we = (state_q == ST_EXEC) && !halt_q && ex_reg;
	assign rf_wd = ex_val;

	// control and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_CLEAR;
			clr_q     <= '0;
			pc_q      <= '0;
			cnt_q     <= '0;
			halt_q    <= 1'b0;
			rf_vld_q  <= '0;
			out_valid <= 1'b0;
		end else begin
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == (MA_W+1)'(DATA_WORDS - 1))
						state_q <= ST_IDLE;
				end
				ST_IDLE: if (in_valid) state_q <= ST_RREG;
				ST_RREG: state_q <= ST_MEM;
				ST_MEM: begin
					if (div_start) state_q <= ST_DIV;
					else if (op_q == OP_MUL) state_q <= ST_MUL;
					else state_q <= ST_EXEC;
				end
				ST_MUL: state_q <= ST_EXEC;
				ST_DIV: if (div_done) state_q <= ST_EXEC;
				ST_EXEC: begin
					if (!halt_q) begin
						cnt_q <= cnt_q + 32'd1;
						pc_q  <= ex_pc;
						if (op_q == OP_HALT) halt_q <= 1'b1;
						if (ex_reg) rf_vld_q[rf_wa] <= 1'b1;
					end
					out_valid <= 1'b1;
					state_q   <= ST_OUT;
				end
				ST_OUT: if (!out_stall) begin
					out_valid <= 1'b0;
					state_q   <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_valid) begin
			op_q  <= op_t'(op);
			dst_q <= dst;
			sa_q  <= src_a;
			sb_q  <= src_b;
			imm_q <= immediate;
			tgt_q <= target;
		end
		if (state_q == ST_EXEC) begin
			next_pc        <= 10'(halt_q ? pc_q : ex_pc);
			halted         <= halt_q || (op_q == OP_HALT);
			reg_written    <= !halt_q && ex_reg;
			written_reg    <= (!halt_q && ex_reg) ? dst_q : 5'd0;
			written_value  <= halt_q ? 32'd0 : ex_val;
			mem_written    <= !halt_q && ex_memw;
			mem_index      <= halt_q ? 10'd0 : ex_midx;
			fault_code     <= halt_q ? FLT_NONE : ex_flt;
			executed_count <= halt_q ? cnt_q : cnt_q + 32'd1;
		end
	end

	assign in_stall = (state_q != ST_IDLE);

	// checks
	a_out_in_state: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (state_q == ST_OUT)) else $error("result valid outside output state");
	a_no_take_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CLEAR) |-> in_stall) else $error("input open during clear");
	a_halt_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		$past(halt_q) |-> halt_q) else $error("halt flag dropped");
	a_no_wr_halt: assert property (@(posedge clk) disable iff (!arst_n)
		halt_q |-> !rf_we) else $error("register write after halt");

endmodule
